@@ hw/rtl/asseq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package asseq_pkg;

  // Fixed field widths
  localparam int unsigned OPC_W    = 2;
  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned AVG_W    = 16;
  localparam int unsigned WARM_W   = 8;
  localparam int unsigned SHIFT_W  = 3;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 1'd1;

  // Configuration reset values
  localparam logic [WARM_W-1:0]  WARMUP_RESET = 8'h04;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET  = 3'd2;
  localparam logic [WARM_W-1:0]  WARM_MAX     = 8'hFF;

  typedef enum logic [OPC_W-1:0] {
    OP_REQUEST = 2'd0,
    OP_DONE    = 2'd1,
    OP_AVERAGE = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    op_t                 opcode;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;
  } req_t;

  typedef struct packed {
    logic                start_valid;
    logic [CHAN_W-1:0]   start_channel;
    logic [AVG_W-1:0]    average;
    logic                any_pending;
  } rsp_t;

  // One word of the per-channel table
  typedef struct packed {
    logic [SAMPLE_W-1:0] result;
    logic [AVG_W-1:0]    sum;
    logic [AVG_W-1:0]    avg;
  } entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/asseq_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface asseq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/asseq_pick.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Lowest-numbered set flag
module asseq_pick #(
  parameter int unsigned N = 12,
  parameter int unsigned W = 4
) (
  input  wire logic [N-1:0] flags,
  output logic              found,
  output logic [W-1:0]      idx
);

  // Scan from the top so the lowest set flag wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (flags[i]) begin
        found = 1'b1;
        idx   = W'(i);
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/adc_scan_sequencer_with_averaging.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Payload
// req      sink       opcode, channel, sample
// rsp      source     start_valid, start_channel, average, any_pending
// cfg      write      cfg_we, cfg_index, cfg_data (warmup_count, average_shift)
//
// For each transaction the accept edge reads the channel table; the edge on
// which the execute state fires writes it back and loads the result register.
// The single read-modify-write of the table keeps one item in work at once.
// A new transaction is taken while the previous result waits in its register.
// Reset (rst, synchronous) clears flags, counters and the table valid bits;
// an entry never written reads as zero. No clearing pass is needed.
module adc_scan_sequencer_with_averaging
  import asseq_pkg::*;
#(
  parameter int unsigned CHANNELS    = 12,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  asseq_stream_if.sink              req,
  asseq_stream_if.source            rsp,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CHANNELS-1:0] FLAG_ONE = CHANNELS'(1);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    SAMPLE_W'((32'd1 << SAMPLE_BITS) - 32'd1);

  // Configuration registers
  logic [WARM_W-1:0]  warmup_count;
  logic [SHIFT_W-1:0] average_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_count  <= WARMUP_RESET;
      average_shift <= SHIFT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WARMUP: warmup_count  <= cfg_data;
        CFG_SHIFT:  average_shift <= SHIFT_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Control state
  state_t              state, state_next;
  logic [CHANNELS-1:0] pending_flags, pending_flags_next;
  logic [WARM_W-1:0]   warmup_counter, warmup_counter_next;
  logic                busy, busy_next;
  logic [CH_W-1:0]     active_channel, active_channel_next;
  logic                out_valid;
  rsp_t                out_data, out_data_next;

  // Latched transaction
  op_t                 op_q;
  logic [CH_W-1:0]     addr_q;
  logic                in_range_q;
  logic [SAMPLE_W-1:0] smp_q;

  // Channel table and its valid bits
  entry_t              table_mem [CHANNELS];
  logic [CHANNELS-1:0] entry_ok;
  entry_t              rd_q;
  logic                rd_ok;
  logic                wr_en;
  entry_t              wr_data;

  logic            in_fire, exec_fire;
  logic            in_range;
  logic [CH_W-1:0] rd_addr;

  assign in_fire   = req.valid && req.ready;
  assign exec_fire = (state == ST_EXEC) && (!out_valid || rsp.ready);
  assign in_range  = (32'(req.data.channel) < 32'(CHANNELS));

  // Choose the table entry for the incoming transaction
  always_comb begin
    if (req.data.opcode == OP_DONE) begin
      rd_addr = active_channel;
    end else if (in_range) begin
      rd_addr = CH_W'(req.data.channel);
    end else begin
      rd_addr = '0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire) state_next = ST_EXEC;
      ST_EXEC: if (exec_fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    req.ready = (state == ST_IDLE);
    rsp.valid = out_valid;
    rsp.data  = out_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the transaction and read the table
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q       <= req.data.opcode;
      addr_q     <= rd_addr;
      in_range_q <= in_range;
      smp_q      <= req.data.sample & SAMPLE_MASK;
      rd_q       <= table_mem[rd_addr];
      rd_ok      <= entry_ok[rd_addr];
    end
  end

  // Lowest pending channel once the finished one is cleared
  logic [CHANNELS-1:0] flags_done;
  logic                pick_found;
  logic [CH_W-1:0]     pick_idx;

  assign flags_done = pending_flags & ~(FLAG_ONE << addr_q);

  asseq_pick #(
    .N (CHANNELS),
    .W (CH_W)
  ) u_pick (
    .flags (flags_done),
    .found (pick_found),
    .idx   (pick_idx)
  );

  // Execute: modify the entry and form the result
  entry_t          cur;
  logic [AVG_W-1:0] sum_add;
  logic [AVG_W-1:0] sum_adj;

  always_comb begin
    cur                 = rd_ok ? rd_q : '0;
    pending_flags_next  = pending_flags;
    warmup_counter_next = warmup_counter;
    busy_next           = busy;
    active_channel_next = active_channel;
    wr_en               = 1'b0;
    wr_data             = cur;
    out_data_next       = '0;
    sum_add             = cur.sum + AVG_W'(cur.result);
    sum_adj             = sum_add;

    case (op_q)
      OP_REQUEST: begin
        if (in_range_q) begin
          pending_flags_next = pending_flags | (FLAG_ONE << addr_q);
          if (!busy) begin
            busy_next                   = 1'b1;
            active_channel_next         = addr_q;
            out_data_next.start_valid   = 1'b1;
            out_data_next.start_channel = CHAN_W'(addr_q);
          end
          out_data_next.average = cur.avg;
        end
      end
      OP_DONE: begin
        if (busy) begin
          wr_en              = 1'b1;
          wr_data.result     = smp_q;
          pending_flags_next = flags_done;
          busy_next          = pick_found;
          if (pick_found) begin
            active_channel_next         = pick_idx;
            out_data_next.start_valid   = 1'b1;
            out_data_next.start_channel = CHAN_W'(pick_idx);
          end
        end
        out_data_next.average = cur.avg;
      end
      OP_AVERAGE: begin
        if (in_range_q) begin
          if (warmup_counter != WARM_MAX) begin
            warmup_counter_next = warmup_counter + 1'b1;
          end
          wr_en = 1'b1;
          if (warmup_counter_next > warmup_count) begin
            if (sum_add > cur.avg) begin
              sum_adj = sum_add - cur.avg;
            end
            wr_data.avg = sum_adj >> average_shift;
          end
          wr_data.sum           = sum_adj;
          out_data_next.average = wr_data.avg;
        end
      end
      default: ;
    endcase

    out_data_next.any_pending = |pending_flags_next;
  end

  // Commit control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_flags  <= '0;
      warmup_counter <= '0;
      busy           <= 1'b0;
      active_channel <= '0;
      entry_ok       <= '0;
    end else if (exec_fire) begin
      pending_flags  <= pending_flags_next;
      warmup_counter <= warmup_counter_next;
      busy           <= busy_next;
      active_channel <= active_channel_next;
      if (wr_en) begin
        entry_ok[addr_q] <= 1'b1;
      end
    end
  end

  // Write back the table entry
  always_ff @(posedge clk) begin
    if (exec_fire && wr_en) begin
      table_mem[addr_q] <= wr_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_data <= out_data_next;
    end
  end

endmodule

`default_nettype wire
